// ===== rtl/spc_pkg.sv =====
// Shared constants for the strong pseudoprime classifier.
package spc_pkg;

    localparam int NUM_WIDTH_DEF = 32;

    // Fixed Miller-Rabin bases that decide primality below 2^32
    localparam logic [31:0] BASE_A = 32'd2;
    localparam logic [31:0] BASE_B = 32'd7;
    localparam logic [31:0] BASE_C = 32'd61;

    // Reset value of the probe base register
    localparam logic [31:0] PROBE_RESET = 32'd2;

endpackage

// ===== rtl/spc_if.sv =====
// Valid/ready channel interfaces for candidate, configuration and result requests.
interface spc_cand_if #(
    parameter int NUM_WIDTH = spc_pkg::NUM_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface spc_cfg_if #(
    parameter int NUM_WIDTH = spc_pkg::NUM_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] probe_base;

    modport source (output valid, output probe_base, input ready);
    modport sink   (input valid, input probe_base, output ready);
endinterface

interface spc_res_if;
    logic valid;
    logic ready;
    logic odd_composite;
    logic base_liar;

    modport source (output valid, output odd_composite, output base_liar, input ready);
    modport sink   (input valid, input odd_composite, input base_liar, output ready);
endinterface

// ===== rtl/strong_pseudoprime_classifier.sv =====
// Strong pseudoprime classifier: Miller-Rabin sequencer around one shared modular multiplier.
//
// Each candidate request is classified by strong probable prime tests to the bases 2, 7
// and 61, which decide primality exactly below 2^32. An odd candidate that fails one of
// them is flagged odd_composite and is then tested once more against the probe base
// register; base_liar reports whether it passes that test. Even candidates return both
// flags clear in the cycle after acceptance; the value one returns odd_composite set and
// base_liar clear. A fixed base that is a multiple of the candidate counts as passing,
// while a probe base that is a multiple of the candidate fails. All arithmetic runs
// through one shift-and-add modular multiplier that retires one multiplier bit per cycle.
// Per base the block spends one multiply on the base reduction, up to two multiplies per
// bit of the odd part u of n-1 for the power, and up to t-1 further squarings
// (n-1 = u * 2^t), plus one decision in S_PBIT per exponent bit. A prime runs all three
// fixed tests and a composite up to four, the probe test included. The candidate
// channel is not ready from acceptance until the result request has been taken. The
// probe base register is written through its own channel, which is always ready, and
// must only be written while no candidate is in flight.
module strong_pseudoprime_classifier #(
    parameter int NUM_WIDTH = spc_pkg::NUM_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spc_cand_if.sink       i_cand,
    spc_cfg_if.sink        i_cfg,
    spc_res_if.source      o_res
);

    localparam int W  = NUM_WIDTH;
    localparam int TW = $clog2(W);      // holds t, at most W-1
    localparam int CW = $clog2(W + 1);  // holds the multiply bit count W

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SPLIT = 9'b000000010,
        S_RED   = 9'b000000100,
        S_PBIT  = 9'b000001000,
        S_PMUL  = 9'b000010000,
        S_PSQ   = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_SQR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        BSEL_A     = 2'd0,
        BSEL_B     = 2'd1,
        BSEL_C     = 2'd2,
        BSEL_PROBE = 2'd3
    } t_base_sel;

    // Sequencer state
    t_state    r_state, n_state;
    t_base_sel r_bsel, n_bsel;
    logic [W-1:0]  r_probe;
    logic [W-1:0]  r_n, n_n;       // candidate
    logic [W-1:0]  r_u, n_u;       // odd part of n-1
    logic [TW-1:0] r_t, n_t;       // power of two in n-1
    logic [TW-1:0] r_i, n_i;       // squaring loop index
    logic [W-1:0]  r_x, n_x;       // running power / witness value
    logic [W-1:0]  r_b, n_b;       // squared base
    logic [W-1:0]  r_e, n_e;       // remaining exponent
    logic          r_comp, n_comp;
    logic          r_liar, n_liar;

    // Shared modular multiplier
    logic [W-1:0]  r_mm_acc, n_mm_acc;
    logic [W-1:0]  r_mm_x, n_mm_x;
    logic [W-1:0]  r_mm_y, n_mm_y;
    logic [CW-1:0] r_mm_cnt, n_mm_cnt;

    logic [W+1:0]  mm_sum;
    logic [W+1:0]  n_ext;
    logic [W+1:0]  n2_ext;
    logic [W-1:0]  mm_res;
    logic          mm_last;
    logic [W-1:0]  n_minus_1;

    logic          launch;
    logic [W-1:0]  la_x;
    logic [W-1:0]  la_y;
    logic          dec;
    logic          dec_pass;
    t_base_sel     next_bsel;

    function automatic logic [W-1:0] base_val(input t_base_sel s, input logic [W-1:0] probe);
        logic [W-1:0] v;
        case (s)
            BSEL_A:     v = W'(spc_pkg::BASE_A);
            BSEL_B:     v = W'(spc_pkg::BASE_B);
            BSEL_C:     v = W'(spc_pkg::BASE_C);
            BSEL_PROBE: v = probe;
            default:    v = probe;
        endcase
        return v;
    endfunction

    // n is odd whenever it is used here, so n-1 just clears bit zero
    assign n_minus_1 = {r_n[W-1:1], 1'b0};

    // One multiplier bit per cycle: acc = 2*acc + bit*x, reduced from below 3n into [0, n)
    assign n_ext  = {2'b00, r_n};
    assign n2_ext = {1'b0, r_n, 1'b0};
    assign mm_sum = {1'b0, r_mm_acc, 1'b0} + (r_mm_y[W-1] ? {2'b00, r_mm_x} : '0);
    assign mm_res = (mm_sum >= n2_ext) ? W'(mm_sum - n2_ext) :
                    (mm_sum >= n_ext)  ? W'(mm_sum - n_ext)  : mm_sum[W-1:0];
    assign mm_last = (r_mm_cnt == CW'(1));

    always_comb begin
        n_state  = r_state;
        n_bsel   = r_bsel;
        n_n      = r_n;
        n_u      = r_u;
        n_t      = r_t;
        n_i      = r_i;
        n_x      = r_x;
        n_b      = r_b;
        n_e      = r_e;
        n_comp   = r_comp;
        n_liar   = r_liar;
        launch   = 1'b0;
        la_x     = r_x;
        la_y     = r_x;
        dec      = 1'b0;
        dec_pass = 1'b0;
        next_bsel = t_base_sel'(r_bsel + 2'd1);

        // advance the multiplier whenever it is running
        n_mm_acc = r_mm_acc;
        n_mm_x   = r_mm_x;
        n_mm_y   = r_mm_y;
        n_mm_cnt = r_mm_cnt;
        if (r_mm_cnt != '0) begin
            n_mm_acc = mm_res;
            n_mm_y   = r_mm_y << 1;
            n_mm_cnt = r_mm_cnt - CW'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_cand.valid) begin
                    n_n = i_cand.candidate;
                    if (!i_cand.candidate[0]) begin
                        n_comp  = 1'b0;
                        n_liar  = 1'b0;
                        n_state = S_DONE;
                    end else if (i_cand.candidate == W'(1)) begin
                        n_comp  = 1'b1;
                        n_liar  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_u     = {i_cand.candidate[W-1:1], 1'b0};
                        n_t     = '0;
                        n_state = S_SPLIT;
                    end
                end
            end
            S_SPLIT: begin
                // strip trailing zeros of n-1 one bit per cycle
                if (!r_u[0]) begin
                    n_u = r_u >> 1;
                    n_t = r_t + TW'(1);
                end else begin
                    n_bsel  = BSEL_A;
                    launch  = 1'b1;
                    la_x    = W'(1);
                    la_y    = base_val(BSEL_A, r_probe);
                    n_state = S_RED;
                end
            end
            S_RED: begin
                // base mod n, computed as 1 * base
                if (mm_last) begin
                    if (mm_res == '0) begin
                        dec      = 1'b1;
                        dec_pass = (r_bsel != BSEL_PROBE);
                    end else begin
                        n_x     = W'(1);
                        n_b     = mm_res;
                        n_e     = r_u;
                        n_state = S_PBIT;
                    end
                end
            end
            S_PBIT: begin
                if (r_e == '0) begin
                    n_state = S_CHECK;
                end else if (r_e[0]) begin
                    launch  = 1'b1;
                    la_x    = r_x;
                    la_y    = r_b;
                    n_state = S_PMUL;
                end else begin
                    launch  = 1'b1;
                    la_x    = r_b;
                    la_y    = r_b;
                    n_state = S_PSQ;
                end
            end
            S_PMUL: begin
                if (mm_last) begin
                    n_x     = mm_res;
                    launch  = 1'b1;
                    la_x    = r_b;
                    la_y    = r_b;
                    n_state = S_PSQ;
                end
            end
            S_PSQ: begin
                if (mm_last) begin
                    n_b     = mm_res;
                    n_e     = r_e >> 1;
                    n_state = S_PBIT;
                end
            end
            S_CHECK: begin
                if (r_x == W'(1) || r_x == n_minus_1) begin
                    dec      = 1'b1;
                    dec_pass = 1'b1;
                end else if (r_t > TW'(1)) begin
                    n_i     = TW'(1);
                    launch  = 1'b1;
                    la_x    = r_x;
                    la_y    = r_x;
                    n_state = S_SQR;
                end else begin
                    dec = 1'b1;
                end
            end
            S_SQR: begin
                if (mm_last) begin
                    n_x = mm_res;
                    if (mm_res == W'(1)) begin
                        dec = 1'b1;
                    end else if (mm_res == n_minus_1) begin
                        dec      = 1'b1;
                        dec_pass = 1'b1;
                    end else if (({1'b0, r_i} + (TW+1)'(1)) < {1'b0, r_t}) begin
                        n_i    = r_i + TW'(1);
                        launch = 1'b1;
                        la_x   = mm_res;
                        la_y   = mm_res;
                    end else begin
                        dec = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Verdict of one strong test: pick the next base or finish
        if (dec) begin
            if (r_bsel == BSEL_PROBE) begin
                n_comp  = 1'b1;
                n_liar  = dec_pass;
                n_state = S_DONE;
            end else if (!dec_pass) begin
                n_bsel  = BSEL_PROBE;
                launch  = 1'b1;
                la_x    = W'(1);
                la_y    = r_probe;
                n_state = S_RED;
            end else if (r_bsel == BSEL_C) begin
                n_comp  = 1'b0;
                n_liar  = 1'b0;
                n_state = S_DONE;
            end else begin
                n_bsel  = next_bsel;
                launch  = 1'b1;
                la_x    = W'(1);
                la_y    = base_val(next_bsel, r_probe);
                n_state = S_RED;
            end
        end

        if (launch) begin
            n_mm_acc = '0;
            n_mm_x   = la_x;
            n_mm_y   = la_y;
            n_mm_cnt = CW'(W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mm_cnt <= '0;
            r_probe  <= W'(spc_pkg::PROBE_RESET);
        end else begin
            r_state  <= n_state;
            r_mm_cnt <= n_mm_cnt;
            if (i_cfg.valid) begin
                r_probe <= i_cfg.probe_base;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        r_bsel   <= n_bsel;
        r_n      <= n_n;
        r_u      <= n_u;
        r_t      <= n_t;
        r_i      <= n_i;
        r_x      <= n_x;
        r_b      <= n_b;
        r_e      <= n_e;
        r_comp   <= n_comp;
        r_liar   <= n_liar;
        r_mm_acc <= n_mm_acc;
        r_mm_x   <= n_mm_x;
        r_mm_y   <= n_mm_y;
    end

    // Hold the candidate channel off from acceptance until the result request is taken
    assign i_cand.ready        = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_res.valid         = (r_state == S_DONE);
    assign o_res.odd_composite = r_comp;
    assign o_res.base_liar     = r_liar;

endmodule

// ===== rtl/spc_checker.sv =====
// Port-level assertions for the strong pseudoprime classifier, with their bind.
module spc_checker #(
    parameter int NUM_WIDTH = spc_pkg::NUM_WIDTH_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic [NUM_WIDTH-1:0] i_in_cand,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_out_comp,
    input logic                 i_out_liar
);

    // A liar flag only comes with an odd composite
    a_liar_needs_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_comp || !i_out_liar))
        else $error("base_liar set without odd_composite");

    // Even candidates finish at once with both flags clear
    a_even_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_cand[0]) |=>
            (i_out_valid && !i_out_comp && !i_out_liar))
        else $error("even candidate not answered with zero flags");

    // One request in flight: no new candidate once one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("candidate channel ready right after acceptance");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_out_valid && i_in_ready))
        else $error("result pending while candidate channel is ready");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_comp) && $stable(i_out_liar)))
        else $error("stalled result request changed");

endmodule

bind strong_pseudoprime_classifier spc_checker #(
    .NUM_WIDTH (NUM_WIDTH)
) u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cand.valid),
    .i_in_ready  (i_cand.ready),
    .i_in_cand   (i_cand.candidate),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_comp  (o_res.odd_composite),
    .i_out_liar  (o_res.base_liar)
);
